// ----- src/nsc_pkg.sv -----
// ----------------------------------------------------------------------------
// nsc_pkg - NMEA sentence capture shared definitions
// Character codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package nsc_pkg;

  localparam int BYTE_W = 8;
  localparam int TAG_W  = 24;
  localparam int POS_W  = 7;   // store_position / comma_position port width
  localparam int SLOT_W = 4;   // comma_slot port width

  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
  localparam logic [BYTE_W-1:0] CH_A      = 8'h41;

  // "GGA", first character in the top byte
  localparam logic [TAG_W-1:0] TAG_RESET = {CH_G, CH_G, CH_A};

  localparam int BUF_DEPTH_DEF   = 128;
  localparam int COMMA_SLOTS_DEF = 16;

endpackage

// ----- src/nsc_in_if.sv -----
// ----------------------------------------------------------------------------
// nsc_in_if - received byte channel
// valid/ready channel carrying one serial character per transfer.
// ----------------------------------------------------------------------------
interface nsc_in_if import nsc_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);

endinterface

// ----- src/nsc_out_if.sv -----
// ----------------------------------------------------------------------------
// nsc_out_if - capture result channel
// valid/ready channel carrying one buffer write / comma record per transfer.
// ----------------------------------------------------------------------------
interface nsc_out_if import nsc_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              store_valid;
  logic [POS_W-1:0]  store_position;
  logic [BYTE_W-1:0] store_byte;
  logic              comma_valid;
  logic [SLOT_W-1:0] comma_slot;
  logic [POS_W-1:0]  comma_position;
  logic              capturing;
  logic              overflow;

  modport source (
    output valid, output store_valid, output store_position, output store_byte,
    output comma_valid, output comma_slot, output comma_position,
    output capturing, output overflow, input ready
  );
  modport sink (
    input valid, input store_valid, input store_position, input store_byte,
    input comma_valid, input comma_slot, input comma_position,
    input capturing, input overflow, output ready
  );

endinterface

// ----- src/nmea_sentence_capture_core.sv -----
// ----------------------------------------------------------------------------
// nmea_sentence_capture_core - NMEA sentence type capture
// Watches a serial byte stream for a sentence type and reports buffer writes.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one received character per transfer (rx_byte).
//   out_ch : one result per input byte: optional buffer write (position and
//            byte), optional comma record (slot and position), and the
//            capturing / overflow flags as they stand after that byte.
//   cfg_*  : cfg_wr_en writes cfg_wr_data into the 24-bit sentence tag
//            (first character in the top byte). Write only while idle.
// Latency: the result for a byte is on out_ch the cycle after its transfer.
// Throughput: one byte per cycle while out_ch is not held off. All state updates are a compare and an
//   increment done in the cycle of the input transfer, into the state and result
//   registers; nothing iterates.
// Reset (rst_n low, synchronous): capture off, window, write position, comma
//   count and overflow cleared, tag back to "GGA", output register empty.
// Stall: while out_ch is held off, the result register keeps its item and
//   in_ch.ready drops; a byte is still taken in the cycle the held result
//   transfers out.
// ----------------------------------------------------------------------------
module nmea_sentence_capture_core
  import nsc_pkg::*;
#(
  parameter int BUF_DEPTH   = BUF_DEPTH_DEF,    // 8 .. 128
  parameter int COMMA_SLOTS = COMMA_SLOTS_DEF   // 2 .. 16
) (
  input  logic             clk,
  input  logic             rst_n,
  nsc_in_if.sink           in_ch,
  nsc_out_if.source        out_ch,
  input  logic             cfg_wr_en,
  input  logic [TAG_W-1:0] cfg_wr_data
);

  // counters must be able to hold the full count itself
  localparam int IDX_W = $clog2(BUF_DEPTH + 1);
  localparam int CNT_W = $clog2(COMMA_SLOTS + 1);
  localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(BUF_DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(COMMA_SLOTS);

  // ---- state ----
  logic [TAG_W-1:0] tag_r;
  logic             capture_r,  capture_nxt;
  logic [TAG_W-1:0] recent_r,   recent_nxt;
  logic [IDX_W-1:0] widx_r,     widx_nxt;
  logic [CNT_W-1:0] ccnt_r,     ccnt_nxt;
  logic             ovf_r,      ovf_nxt;

  // ---- result register ----
  logic              out_valid_r;
  logic              st_v_r,    st_v_nxt;
  logic [POS_W-1:0]  st_pos_r,  st_pos_nxt;
  logic [BYTE_W-1:0] st_b_r,    st_b_nxt;
  logic              cm_v_r,    cm_v_nxt;
  logic [SLOT_W-1:0] cm_slot_r, cm_slot_nxt;
  logic [POS_W-1:0]  cm_pos_r,  cm_pos_nxt;

  logic in_xfer;
  logic [BYTE_W-1:0] b;

  // zero-extended views so the low port bits can be taken for any depth
  logic [IDX_W+POS_W-1:0]  widx_ext;
  logic [CNT_W+SLOT_W-1:0] ccnt_ext;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;

  assign widx_ext = {{POS_W{1'b0}}, widx_r};
  assign ccnt_ext = {{SLOT_W{1'b0}}, ccnt_r};

  always_comb begin
    capture_nxt = capture_r;
    recent_nxt  = recent_r;
    widx_nxt    = widx_r;
    ccnt_nxt    = ccnt_r;
    ovf_nxt     = ovf_r;
    st_v_nxt    = 1'b0;
    st_pos_nxt  = '0;
    st_b_nxt    = '0;
    cm_v_nxt    = 1'b0;
    cm_slot_nxt = '0;
    cm_pos_nxt  = '0;

    priority if (b == CH_DOLLAR) begin
      // restart; window left alone
      capture_nxt = 1'b0;
      widx_nxt    = '0;
      ccnt_nxt    = '0;
      ovf_nxt     = 1'b0;
    end else if (capture_r) begin
      if (widx_r != IDX_FULL) begin
        if (b == CH_COMMA) begin
          if (ccnt_r != CNT_FULL) begin
            cm_v_nxt    = 1'b1;
            cm_slot_nxt = ccnt_ext[SLOT_W-1:0];
            cm_pos_nxt  = widx_ext[POS_W-1:0];
            ccnt_nxt    = ccnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;   // comma slots exhausted, byte still stored
          end
        end
        st_v_nxt   = 1'b1;
        st_pos_nxt = widx_ext[POS_W-1:0];
        st_b_nxt   = b;
        widx_nxt   = widx_r + IDX_W'(1);
      end else begin
        ovf_nxt = 1'b1;       // buffer full
      end
    end else if (recent_r == tag_r) begin
      // byte after the tag is consumed and starts capture
      capture_nxt = 1'b1;
      recent_nxt  = '0;
    end else begin
      recent_nxt = {recent_r[TAG_W-BYTE_W-1:0], b};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r       <= TAG_RESET;
      capture_r   <= 1'b0;
      recent_r    <= '0;
      widx_r      <= '0;
      ccnt_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tag_r <= cfg_wr_data;
      end
      if (in_xfer) begin
        capture_r   <= capture_nxt;
        recent_r    <= recent_nxt;
        widx_r      <= widx_nxt;
        ccnt_r      <= ccnt_nxt;
        ovf_r       <= ovf_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      st_v_r    <= st_v_nxt;
      st_pos_r  <= st_pos_nxt;
      st_b_r    <= st_b_nxt;
      cm_v_r    <= cm_v_nxt;
      cm_slot_r <= cm_slot_nxt;
      cm_pos_r  <= cm_pos_nxt;
    end
  end

  // flags after the byte are exactly the updated state registers
  assign out_ch.valid          = out_valid_r;
  assign out_ch.store_valid    = st_v_r;
  assign out_ch.store_position = st_pos_r;
  assign out_ch.store_byte     = st_b_r;
  assign out_ch.comma_valid    = cm_v_r;
  assign out_ch.comma_slot     = cm_slot_r;
  assign out_ch.comma_position = cm_pos_r;
  assign out_ch.capturing      = capture_r;
  assign out_ch.overflow       = ovf_r;

  // ---- assertions ----
  a_store_implies_capture: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && st_v_r |-> capture_r)
    else $error("buffer write reported while not capturing");

  a_comma_is_stored_comma: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && cm_v_r |-> st_v_r && (st_b_r == CH_COMMA))
    else $error("comma record without a stored comma byte");

  a_dollar_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (b == CH_DOLLAR) |=> !capture_r && (widx_r == '0) && (ccnt_r == '0) && !ovf_r)
    else $error("restart byte did not clear capture state");

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (widx_r <= IDX_FULL) && (ccnt_r <= CNT_FULL))
    else $error("write position or comma count past its limit");

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - NMEA sentence capture core regression
// Feeds byte streams shaped like NMEA sentences (clean, broken and noisy)
// through the core under several sentence tags and handshake idle mixes.
// A scoreboard predicts every result in its own model and checks each
// result transfer field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import nsc_pkg::*;

  localparam int          PHASE_ITEMS = 100;      // minimum random bytes per phase, 6 phases
  localparam int          LONG_STALL  = 80;       // receiver hold-off length, cycles
  localparam int          CYCLE_LIMIT = 200_000;
  localparam logic [TAG_W-1:0] TAG_RMC  = {8'h52, 8'h4D, 8'h43};
  localparam logic [TAG_W-1:0] TAG_ZERO = '0;
  localparam logic [TAG_W-1:0] TAG_ONES = '1;
  localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;

  // One result transfer, in port order.
  typedef struct packed {
    logic              store_valid;
    logic [POS_W-1:0]  store_position;
    logic [BYTE_W-1:0] store_byte;
    logic              comma_valid;
    logic [SLOT_W-1:0] comma_slot;
    logic [POS_W-1:0]  comma_position;
    logic              capturing;
    logic              overflow;
  } capture_result_t;

  // Capture predictor plus the queue of results still owed by the core.
  class capture_scoreboard;
    logic [TAG_W-1:0]  tag;
    logic              capture_on;
    logic [TAG_W-1:0]  window;
    int                wr_pos;
    int                comma_cnt;
    logic              ovf;
    capture_result_t   owed_q[$];
    int                errors;

    function new();
      tag        = TAG_RESET;
      capture_on = 1'b0;
      window     = '0;
      wr_pos     = 0;
      comma_cnt  = 0;
      ovf        = 1'b0;
      errors     = 0;
    endfunction

    function void set_tag(logic [TAG_W-1:0] t);
      tag = t;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Accepted input byte: advance the model, queue the result it owes.
    function void note_byte(logic [BYTE_W-1:0] b);
      capture_result_t r;
      r = '0;
      if (b == CH_DOLLAR) begin
        // restart; window kept as is
        wr_pos     = 0;
        comma_cnt  = 0;
        capture_on = 1'b0;
        ovf        = 1'b0;
      end else if (capture_on) begin
        if (wr_pos < BUF_DEPTH_DEF) begin
          if (b == CH_COMMA) begin
            if (comma_cnt < COMMA_SLOTS_DEF) begin
              r.comma_valid    = 1'b1;
              r.comma_slot     = SLOT_W'(comma_cnt);
              r.comma_position = POS_W'(wr_pos);
              comma_cnt++;
            end else begin
              ovf = 1'b1;
            end
          end
          r.store_valid    = 1'b1;
          r.store_position = POS_W'(wr_pos);
          r.store_byte     = b;
          wr_pos++;
        end else begin
          ovf = 1'b1;
        end
      end else if (window == tag) begin
        // byte after the tag is eaten and starts capture
        capture_on = 1'b1;
        window     = '0;
      end else begin
        window = {window[TAG_W-BYTE_W-1:0], b};
      end
      r.capturing = capture_on;
      r.overflow  = ovf;
      owed_q.push_back(r);
    endfunction

    task report(string what, logic [31:0] got_v, logic [31:0] exp_v);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got_v, exp_v);
      errors++;
    endtask

    task check_field(string what, logic [31:0] got_v, logic [31:0] exp_v);
      if (got_v !== exp_v) report(what, got_v, exp_v);
    endtask

    task check_result(capture_result_t got);
      capture_result_t want;
      if (owed_q.size() == 0) begin
        report("result with nothing owed", 32'(got), 32'd0);
      end else begin
        want = owed_q.pop_front();
        check_field("store_valid", 32'(got.store_valid), 32'(want.store_valid));
        check_field("store_position", 32'(got.store_position), 32'(want.store_position));
        check_field("store_byte", 32'(got.store_byte), 32'(want.store_byte));
        check_field("comma_valid", 32'(got.comma_valid), 32'(want.comma_valid));
        check_field("comma_slot", 32'(got.comma_slot), 32'(want.comma_slot));
        check_field("comma_position", 32'(got.comma_position), 32'(want.comma_position));
        check_field("capturing", 32'(got.capturing), 32'(want.capturing));
        check_field("overflow", 32'(got.overflow), 32'(want.overflow));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [TAG_W-1:0]  cfg_wr_data;

  nsc_in_if  in_ch ();
  nsc_out_if out_ch ();

  capture_scoreboard sb;

  // Handshake pressure knobs and run counters; all but the cycle count are written by the stimulus process only.
  int                in_idle_pct  = 33;
  int                out_idle_pct = 83;
  int                stall_requests = 0;   // bumped to ask for one long hold-off
  int                sent_items = 0;
  int unsigned       cycles = 0;
  logic [TAG_W-1:0]  cur_tag = TAG_RESET;  // tag the core holds now

  // Directed opener: field extremes, tag match with a non-comma start byte,
  // comma records, restart, and a back-to-back restart.
  logic [BYTE_W-1:0] directed_bytes [$] = '{
    8'h00, 8'hFF, CH_G, CH_G, CH_A, 8'h80, CH_COMMA, 8'h31, CH_COMMA, 8'hFF,
    8'h00, CH_DOLLAR, CH_G, CH_G, CH_A, CH_COMMA, CH_A, CH_COMMA, CH_DOLLAR,
    CH_DOLLAR
  };

  nmea_sentence_capture_core #(
    .BUF_DEPTH   (BUF_DEPTH_DEF),
    .COMMA_SLOTS (COMMA_SLOTS_DEF)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Transfer monitor. Values are read at the edge, before any NBA of this
  // step lands, so the sampled handshake is the one the core saw.
  always @(posedge clk) begin
    capture_result_t got;
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_byte(in_ch.rx_byte);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.store_valid, out_ch.store_position, out_ch.store_byte,
             out_ch.comma_valid, out_ch.comma_slot, out_ch.comma_position,
             out_ch.capturing, out_ch.overflow};
      sb.check_result(got);
    end
  end

  // Result receiver: random back-pressure, plus a long hold-off whenever the
  // stimulus asks for one. The hold-off is counted here so the sender keeps
  // offering bytes meanwhile and the core has to stall its input.
  initial begin
    int stall_served;
    int stall_left;
    stall_served = 0;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_served != stall_requests) begin
        stall_served = stall_requests;
        stall_left   = LONG_STALL;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // One byte transfer, with random idle cycles ahead of it. Returns at the
  // edge where the transfer happens; valid is left high so a following byte
  // goes out back to back.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_items++;
  endtask

  // Sender goes quiet until every owed result has transferred.
  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Tag write; only called with the core idle.
  task automatic write_tag(input logic [TAG_W-1:0] t);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_tag = t;
    sb.set_tag(t);
  endtask

  // Sentence field content: commas at the given rate, the rest about half
  // characters 0x30..0x5A and half arbitrary bytes. Never a '$', so the sentence survives.
  function automatic logic [BYTE_W-1:0] field_char(input int comma_pct);
    int pick;
    logic [BYTE_W-1:0] c;
    pick = $urandom_range(99);
    if (pick < comma_pct) return CH_COMMA;
    if (pick < comma_pct + (100 - comma_pct) / 2) return BYTE_W'($urandom_range(8'h30, 8'h5A));
    c = BYTE_W'($urandom_range(255));
    if (c == CH_DOLLAR) c = ~c;
    return c;
  endfunction

  function automatic logic [TAG_W-1:0] phase_tag(input int ph);
    case (ph)
      1:       return TAG_ZERO;
      2:       return TAG_ONES;
      3:       return TAG_W'($urandom);
      4:       return TAG_RMC;
      default: return TAG_RESET;
    endcase
  endfunction

  // One random chunk of traffic. Most chunks are sentences with the current
  // tag, a few without the '$'; the rest are cut-off sentences and line noise.
  // force_long stretches a sentence chunk to near or past the buffer size.
  task automatic send_sentence(input bit force_long);
    int kind;
    int body_len;
    int comma_pct;
    kind      = $urandom_range(9);
    body_len  = $urandom_range(3, 30);
    comma_pct = 15;
    if (kind <= 6) begin
      if (force_long || $urandom_range(15) == 0) begin
        // runs near or past the buffer and, with this comma rate, usually past the slots
        body_len  = $urandom_range(BUF_DEPTH_DEF - 8, BUF_DEPTH_DEF + 22);
        comma_pct = 20;
      end else if (kind == 6) begin
        // comma flood: slots usually run out, the buffer does not
        body_len  = $urandom_range(25, 50);
        comma_pct = 55;
      end
      // now and then no '$', so a capture already running just continues
      if (kind != 5) send_byte(CH_DOLLAR);
      if ($urandom_range(1)) begin
        // talker id ahead of the type, as in "$GPGGA"
        send_byte(BYTE_W'($urandom_range(8'h41, 8'h5A)));
        send_byte(BYTE_W'($urandom_range(8'h41, 8'h5A)));
      end
      send_byte(cur_tag[23:16]);
      send_byte(cur_tag[15:8]);
      send_byte(cur_tag[7:0]);
      // start byte: normally the comma, sometimes anything else
      send_byte(($urandom_range(3) != 0) ? CH_COMMA : field_char(comma_pct));
      repeat (body_len) send_byte(field_char(comma_pct));
      if ($urandom_range(1)) begin
        send_byte(CH_STAR);
        send_byte(BYTE_W'($urandom_range(8'h30, 8'h46)));
        send_byte(BYTE_W'($urandom_range(8'h30, 8'h46)));
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
    end else if (kind == 7) begin
      // type cut short, then restart or junk
      send_byte(CH_DOLLAR);
      send_byte(cur_tag[23:16]);
      if ($urandom_range(1)) send_byte(cur_tag[15:8]);
      if ($urandom_range(1)) send_byte(CH_DOLLAR);
      else repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(255)));
    end else begin
      // raw noise, any byte value including '$'
      repeat ($urandom_range(3, 12)) send_byte(BYTE_W'($urandom_range(255)));
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int start_items;
    int chunk;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part runs on the reset tag and the first idle mix.
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    // Six phases: idle mix changes every two phases (sender 33 / receiver 83,
    // then swapped, then no idling); the tag changes at every phase after
    // the first, always with the core drained.
    for (int ph = 0; ph < 6; ph++) begin
      in_idle_pct  = (ph < 2) ? 33 : (ph < 4) ? 83 : 0;
      out_idle_pct = (ph < 2) ? 83 : (ph < 4) ? 33 : 0;
      if (ph != 0) begin
        wait_all_results();
        write_tag(phase_tag(ph));
      end
      start_items = sent_items;
      chunk = 0;
      while (sent_items - start_items < PHASE_ITEMS) begin
        if ((ph == 1 || ph == 4) && chunk == 3) stall_requests++;
        send_sentence(chunk == 1 && (ph == 2 || ph == 5));
        chunk++;
      end
    end

    // Drain, then wait on to catch any stray result transfer.
    wait_all_results();
    repeat (5) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
